// ----- design/epc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, codes, sine table and arithmetic helpers of the phasor chain.
// ----------------------------------------------------------------------------
package epc_pkg;

	localparam int MAX_PHASORS_DEF = 8;

	localparam int COORD_W  = 16;
	localparam int PHASE_W  = 16;
	localparam int RADIUS_W = 8;
	localparam int CENTER_W = 11;
	localparam int COUNT_W  = 4;
	localparam int TRIG_W   = 17;
	localparam int PROD_W   = 26;
	localparam int OFF_W    = 13;
	localparam int REG_W    = 2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [REG_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [REG_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [REG_W-1:0] REG_PHASORS  = 2'd2;

	localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd960;
	localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd540;
	localparam logic [COUNT_W-1:0]  PHASORS_RST  = 4'd5;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

	// round(32767 * sin(k * pi / 128)), k = 0..64
	localparam logic [14:0] QUARTER_SINE [0:64] = '{
		15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
		15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
		15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
		15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
		15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
		15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
		15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
		15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
		15'd32767
	};

	// Running point handed from cell to cell.
	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} epc_tok_t;

	typedef struct packed {
		logic tick;
		logic xfer;
		logic active;
	} epc_cell_ctl_t;

	typedef struct packed {
		logic                we;
		logic [PHASE_W-1:0]  step;
		logic [RADIUS_W-1:0] radius;
	} epc_load_t;

	function automatic logic signed [TRIG_W-1:0] sine_of(input logic [PHASE_W-1:0] phase);
		logic [1:0]               quad;
		logic [6:0]               idx;
		logic signed [TRIG_W-1:0] v;
		quad = phase[15:14];
		idx  = quad[0] ? (7'd64 - {1'b0, phase[13:8]}) : {1'b0, phase[13:8]};
		v    = $signed({2'b00, QUARTER_SINE[idx]});
		return quad[1] ? -v : v;
	endfunction

	// radius * trig / 2048, rounded with ties toward plus infinity
	function automatic logic signed [OFF_W-1:0] scaled_offset(
		input logic [RADIUS_W-1:0] radius,
		input logic signed [TRIG_W-1:0] trig
	);
		logic signed [PROD_W-1:0] prod;
		prod = PROD_W'($signed({1'b0, radius})) * PROD_W'(trig);
		prod = prod + PROD_W'(1024);
		return $signed(prod[11 +: OFF_W]);
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] a,
		input logic signed [OFF_W-1:0]   b
	);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {{(COORD_W+1-OFF_W){b[OFF_W-1]}}, b};
		if (s[COORD_W] != s[COORD_W-1]) begin
			return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
		return s[COORD_W-1:0];
	endfunction

endpackage

// ----- design/epc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_in_if
// Input item channel: tick or load command.
// ----------------------------------------------------------------------------
interface epc_in_if import epc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [2:0]          entry_index;
	logic [PHASE_W-1:0]  phase_step;
	logic [RADIUS_W-1:0] arm_radius;

	modport source (output valid, operation, entry_index, phase_step, arm_radius, input ready);
	modport sink (input valid, operation, entry_index, phase_step, arm_radius, output ready);
endinterface

// ----- design/epc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_out_if
// Result channel: one chain point per transfer.
// ----------------------------------------------------------------------------
interface epc_out_if import epc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [COUNT_W-1:0]        point_number;
	logic                      last_point;

	modport source (output valid, point_x, point_y, point_number, last_point, input ready);
	modport sink (input valid, point_x, point_y, point_number, last_point, output ready);
endinterface

// ----- design/epc_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface epc_cfg_if import epc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REG_W-1:0]    index;
	logic [CENTER_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/epc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_cell
// One phasor: holds phase, step and radius, keeps its registered x/y offsets
// and adds them to the running point passed in from its left neighbor.
// ----------------------------------------------------------------------------
module epc_cell import epc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  epc_cell_ctl_t ctl,
	input  epc_load_t     load,
	input  epc_tok_t      tok_in,
	output epc_tok_t      tok_out
);

	logic [PHASE_W-1:0]        phase_q;
	logic [PHASE_W-1:0]        step_q;
	logic [RADIUS_W-1:0]       radius_q;
	logic signed [OFF_W-1:0]   cos_off_q;
	logic signed [OFF_W-1:0]   sin_off_q;
	logic                      tok_valid_q;
	logic signed [COORD_W-1:0] tok_x_q;
	logic signed [COORD_W-1:0] tok_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			step_q   <= '0;
			radius_q <= '0;
		end else if (load.we) begin
			phase_q  <= '0;
			step_q   <= load.step;
			radius_q <= load.radius;
		end else if (ctl.tick && ctl.active) begin
			phase_q <= phase_q + step_q;
		end
	end

	// Offsets are registered from the phase and follow it in the next cycle.
	always_ff @(posedge clk) begin
		cos_off_q <= scaled_offset(radius_q, sine_of(phase_q + QUARTER_TURN));
		sin_off_q <= scaled_offset(radius_q, sine_of(phase_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (ctl.xfer) begin
			tok_valid_q <= tok_in.valid && ctl.active;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.xfer && tok_in.valid) begin
			tok_x_q <= sat_add(tok_in.x, cos_off_q);
			tok_y_q <= sat_add(tok_in.y, sin_off_q);
		end
	end

	assign tok_out = '{valid: tok_valid_q, x: tok_x_q, y: tok_y_q};

endmodule

// ----- design/epicycle_point_chain_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epicycle_point_chain_core
// Chain of rotating phasors that emits the points of the epicycle chain.
// ----------------------------------------------------------------------------
// A load item writes one cell's step and radius and clears its phase. A tick
// item runs in steps, n being the number of phasors in use capped at
// MAX_PHASORS: accept the item and advance every active phase at once, let
// every cell register its cosine and sine offsets from the new phase, then
// emit the n + 1 points, one point per cycle while the output is ready, as
// the running point walks the row of cells, the center first. A stalled
// output holds the walk in place. The block takes no new item until the
// last point of a tick has transferred.
// ----------------------------------------------------------------------------
module epicycle_point_chain_core import epc_pkg::*; #(
	parameter int MAX_PHASORS = MAX_PHASORS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	epc_in_if.sink   item,
	epc_out_if.source point,
	epc_cfg_if.sink  cfg
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes to an index beyond the list drop.
	// ------------------------------------------------------------------
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [COUNT_W-1:0]  phasors_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			phasors_q  <= PHASORS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X: center_x_q <= cfg.data;
				REG_CENTER_Y: center_y_q <= cfg.data;
				REG_PHASORS:  phasors_q  <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Active mask: cell i takes part when i is below the phasor count.
	// The extra top bit is always clear so the final cell ends the chain.
	// A running point at position i is the last one when cell i is idle.
	// ------------------------------------------------------------------
	logic [MAX_PHASORS:0] active;

	always_comb begin
		for (int i = 0; i <= MAX_PHASORS; i++) begin
			active[i] = (i < MAX_PHASORS) && (int'(phasors_q) > i);
		end
	end

	// ------------------------------------------------------------------
	// Sequencing: busy from tick acceptance until the last point transfers.
	// start_q holds back the center point so the cells first register offsets of the new phase.
	// ------------------------------------------------------------------
	logic busy_q;
	logic start_q;
	logic item_xfer;
	logic tick_xfer;
	logic load_xfer;
	logic out_xfer;

	epc_tok_t                  tok [MAX_PHASORS+1];
	logic                      tok0_valid_q;
	logic signed [COORD_W-1:0] tok0_x_q;
	logic signed [COORD_W-1:0] tok0_y_q;
	logic [MAX_PHASORS:0]      tok_valid;

	assign item.ready = !busy_q;
	assign item_xfer  = item.valid && item.ready;
	assign tick_xfer  = item_xfer && (item.operation == OP_TICK);
	assign load_xfer  = item_xfer && (item.operation == OP_LOAD);
	assign out_xfer   = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= tick_xfer;
			priority if (tick_xfer) begin
				busy_q <= 1'b1;
			end else if (out_xfer && point.last_point) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Center point enters the row; it leaves on its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_valid_q <= 1'b0;
		end else if (start_q) begin
			tok0_valid_q <= 1'b1;
		end else if (out_xfer) begin
			tok0_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			tok0_x_q <= $signed({1'b0, center_x_q, 4'b0000});
			tok0_y_q <= $signed({1'b0, center_y_q, 4'b0000});
		end
	end

	assign tok[0] = '{valid: tok0_valid_q, x: tok0_x_q, y: tok0_y_q};

	// ------------------------------------------------------------------
	// Row of phasor cells; each passes the running point to its right.
	// ------------------------------------------------------------------
	for (genvar g = 0; g < MAX_PHASORS; g++) begin : g_cell
		epc_cell_ctl_t cell_ctl;
		epc_load_t     cell_load;

		assign cell_ctl.tick   = tick_xfer;
		assign cell_ctl.xfer   = out_xfer;
		assign cell_ctl.active = active[g];

		assign cell_load.we     = load_xfer && (int'(item.entry_index) == g);
		assign cell_load.step   = item.phase_step;
		assign cell_load.radius = item.arm_radius;

		epc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.load    (cell_load),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Output: at most one running point is valid; select it.
	// ------------------------------------------------------------------
	always_comb begin
		point.valid        = 1'b0;
		point.point_x      = '0;
		point.point_y      = '0;
		point.point_number = '0;
		point.last_point   = 1'b0;
		for (int i = 0; i <= MAX_PHASORS; i++) begin
			tok_valid[i] = tok[i].valid;
			if (tok[i].valid) begin
				point.valid        = 1'b1;
				point.point_x      = point.point_x | tok[i].x;
				point.point_y      = point.point_y | tok[i].y;
				point.point_number = point.point_number | COUNT_W'(i);
				point.last_point   = point.last_point | !active[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one running point in the cell row");

	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid || start_q) |-> busy_q)
		else $error("point pending while the block is idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && point.last_point) |=> (!busy_q && tok_valid == '0))
		else $error("tick did not end after its last point");

	a_start_center: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> (tok_valid == {{MAX_PHASORS{1'b0}}, 1'b1}))
		else $error("center point missing at the start of a tick");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the epicycle point chain core. A queue of tick and
// load commands feeds a clocked driver. A clocked monitor compares every
// chain point that leaves the block against a behavioral chain predictor.
// Both channels idle at random. The register set changes between phases,
// and only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import epc_pkg::*;

	localparam int CHAIN_DEPTH = MAX_PHASORS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT  = 10;
	localparam int SETTLE_CYC  = 20;
	localparam int RANDOM_CMDS = 380;

	// Register index with no register behind it; a write there must change nothing.
	localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [PHASE_W-1:0] TURN_QUARTER = 16'h4000;

	// Quarter-wave sine, Q1.15: round(32767 * sin(k * pi / 128)), k = 0..64.
	localparam int SINE_Q [0:64] = '{
		0, 804, 1608, 2410, 3212, 4011, 4808, 5602,
		6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
		12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
		18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
		23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
		27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
		30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
		32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
		32767
	};

	typedef struct packed {
		logic                op;
		logic [2:0]          idx;
		logic [PHASE_W-1:0]  step;
		logic [RADIUS_W-1:0] radius;
	} chain_cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COUNT_W-1:0]        num;
		logic                      last;
	} chain_point_t;

	logic clk;
	logic arst_n;

	epc_in_if  item_if ();
	epc_out_if point_if ();
	epc_cfg_if cfg_if ();

	epicycle_point_chain_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_if),
		.point (point_if),
		.cfg   (cfg_if)
	);

	// Predictor state: register copies and the three phasor tables.
	logic [CENTER_W-1:0] ctr_x;
	logic [CENTER_W-1:0] ctr_y;
	logic [COUNT_W-1:0]  arms_used;
	logic [PHASE_W-1:0]  phase_acc [0:CHAIN_DEPTH-1];
	logic [PHASE_W-1:0]  step_tbl  [0:CHAIN_DEPTH-1];
	logic [RADIUS_W-1:0] radius_tbl[0:CHAIN_DEPTH-1];

	chain_cmd_t   pending_cmds[$];
	chain_point_t expected_points[$];
	chain_cmd_t   cmd_now;

	int  cmd_wait;
	int  ready_wait;
	bit  calm_in;
	bit  calm_out;
	int  cycle_count;
	int  fail_count;
	int  ticks_done;
	int  loads_done;
	int  queued_cmds;
	int  points_checked;
	int  saturated_points;
	int  reg_writes;
	int  random_cmds;

	// 100 MHz clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: end the run if it hangs anywhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points still expected",
				cycle_count, expected_points.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Idle length for one transfer; calm stretches run with no idling at all.
	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// Q1.15 sine of a 16-bit turn fraction, top 8 bits index the table.
	function automatic int table_sine(input logic [PHASE_W-1:0] ph);
		logic [1:0] quad;
		int         k;
		int         v;
		quad = ph[15:14];
		k    = ph[13:8];
		v    = quad[0] ? SINE_Q[64 - k] : SINE_Q[k];
		return quad[1] ? -v : v;
	endfunction

	// Arm offset in 1/16 pixel: floor((r * trig + 1024) / 2048).
	function automatic int arm_offset(input int r, input int trig);
		return (r * trig + 1024) >>> 11;
	endfunction

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Apply one accepted command to the predictor and queue the points of a tick.
	task automatic advance_chain(input chain_cmd_t c);
		int           n;
		int           px;
		int           py;
		int           rx;
		int           ry;
		logic [PHASE_W-1:0] ph;
		chain_point_t p;
		if (c.op == OP_LOAD) begin
			step_tbl[c.idx]   = c.step;
			radius_tbl[c.idx] = c.radius;
			phase_acc[c.idx]  = '0;
			loads_done++;
		end else begin
			n  = (arms_used > CHAIN_DEPTH) ? CHAIN_DEPTH : arms_used;
			px = ctr_x * 16;
			py = ctr_y * 16;
			p.x    = px[COORD_W-1:0];
			p.y    = py[COORD_W-1:0];
			p.num  = '0;
			p.last = (n == 0);
			expected_points = {expected_points, p};
			for (int i = 0; i < n; i++) begin
				ph           = phase_acc[i] + step_tbl[i];
				phase_acc[i] = ph;
				rx = px + arm_offset(radius_tbl[i], table_sine(ph + TURN_QUARTER));
				ry = py + arm_offset(radius_tbl[i], table_sine(ph));
				px = clamp16(rx);
				py = clamp16(ry);
				if (px != rx || py != ry)
					saturated_points++;
				p.x    = px[COORD_W-1:0];
				p.y    = py[COORD_W-1:0];
				p.num  = COUNT_W'(i + 1);
				p.last = (i + 1 == n);
				expected_points = {expected_points, p};
			end
			ticks_done++;
		end
	endtask

	task automatic report_fail(input string msg);
		if (fail_count < SHOW_LIMIT)
			$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Command driver: hold valid until the transfer, then idle for the drawn gap.
	always @(posedge clk) begin : feed_cmds
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = item_if.valid;
			if (item_if.valid && item_if.ready) begin
				advance_chain(cmd_now);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (cmd_wait > 0) begin
					cmd_wait--;
				end else if (pending_cmds.size() > 0) begin
					cmd_now = pending_cmds.pop_front();
					item_if.operation   <= cmd_now.op;
					item_if.entry_index <= cmd_now.idx;
					item_if.phase_step  <= cmd_now.step;
					item_if.arm_radius  <= cmd_now.radius;
					nxt_valid = 1'b1;
					if ($urandom_range(0, 39) == 0)
						calm_in = !calm_in;
					cmd_wait = draw_wait(calm_in);
				end
			end
			item_if.valid <= nxt_valid;
		end
	end

	// Point monitor: compare each transfer with the oldest expected point,
	// then stall ready for the drawn number of cycles.
	always @(posedge clk) begin : watch_points
		chain_point_t got;
		chain_point_t want;
		if (arst_n) begin
			if (point_if.valid && point_if.ready) begin
				got.x    = point_if.point_x;
				got.y    = point_if.point_y;
				got.num  = point_if.point_number;
				got.last = point_if.last_point;
				if (expected_points.size() == 0) begin
					report_fail($sformatf("unexpected point x=%0d y=%0d num=%0d last=%0b",
						got.x, got.y, got.num, got.last));
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.num !== want.num ||
						got.last !== want.last)
						report_fail($sformatf(
							"point mismatch: expected x=%0d y=%0d num=%0d last=%0b, got x=%0d y=%0d num=%0d last=%0b",
							want.x, want.y, want.num, want.last,
							got.x, got.y, got.num, got.last));
					points_checked++;
				end
				if ($urandom_range(0, 29) == 0)
					calm_out = !calm_out;
				ready_wait = draw_wait(calm_out);
			end
			if (ready_wait > 0) begin
				ready_wait--;
				point_if.ready <= 1'b0;
			end else begin
				point_if.ready <= 1'b1;
			end
		end
	end

	task automatic queue_cmd(input logic op, input logic [2:0] idx,
		input logic [PHASE_W-1:0] step, input logic [RADIUS_W-1:0] radius);
		chain_cmd_t c;
		c.op     = op;
		c.idx    = idx;
		c.step   = step;
		c.radius = radius;
		pending_cmds = {pending_cmds, c};
		queued_cmds++;
	endtask

	// Wait until every queued command has transferred and every point has
	// come back, then give a trailing load time to finish inside the block.
	task automatic settle();
		while ((ticks_done + loads_done) != queued_cmds || expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Register write over the config channel; mirror it into the predictor
	// at the transfer.
	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CENTER_W-1:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_CENTER_X: ctr_x = val;
			REG_CENTER_Y: ctr_y = val;
			REG_PHASORS:  arms_used = val[COUNT_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	function automatic logic [CENTER_W-1:0] pick_center();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return CENTER_W'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic logic [CENTER_W-1:0] pick_arms();
		logic [CENTER_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = CENTER_W'(CHAIN_DEPTH);
			2: v = CENTER_W'($urandom_range(CHAIN_DEPTH + 1, 15));
			default: v = CENTER_W'($urandom_range(1, CHAIN_DEPTH));
		endcase
		// Upper data bits are outside the register; drive junk there now and then.
		if ($urandom_range(0, 3) == 0)
			v[CENTER_W-1:COUNT_W] = (CENTER_W-COUNT_W)'($urandom);
		return v;
	endfunction

	initial begin : run_test
		int phase_len;
		int r;
		logic [RADIUS_W-1:0] rad;
		logic [PHASE_W-1:0]  stp;

		arst_n              = 1'b0;
		item_if.valid       = 1'b0;
		item_if.operation   = OP_TICK;
		item_if.entry_index = '0;
		item_if.phase_step  = '0;
		item_if.arm_radius  = '0;
		point_if.ready      = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_CENTER_X;
		cfg_if.data         = '0;
		ctr_x               = CENTER_X_RST;
		ctr_y               = CENTER_Y_RST;
		arms_used           = PHASORS_RST;
		for (int i = 0; i < CHAIN_DEPTH; i++) begin
			phase_acc[i]  = '0;
			step_tbl[i]   = '0;
			radius_tbl[i] = '0;
		end
		cmd_wait         = 0;
		ready_wait       = 0;
		calm_in          = 1'b0;
		calm_out         = 1'b0;
		cycle_count      = 0;
		fail_count       = 0;
		ticks_done       = 0;
		loads_done       = 0;
		queued_cmds      = 0;
		points_checked   = 0;
		saturated_points = 0;
		reg_writes       = 0;
		random_cmds      = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a tick over empty arms, then every arm at full radius.
		queue_cmd(OP_TICK, 3'd5, 16'hFFFF, 8'hFF);
		for (int i = 0; i < CHAIN_DEPTH; i++)
			queue_cmd(OP_LOAD, 3'(i), 16'h0000, 8'hFF);
		queue_cmd(OP_TICK, 3'd0, 16'h0000, 8'h00);
		settle();

		// Far corner with all arms: x runs into positive saturation, then y.
		write_reg(REG_CENTER_X, 11'd2047);
		write_reg(REG_CENTER_Y, 11'd2047);
		write_reg(REG_PHASORS, 11'd8);
		queue_cmd(OP_TICK, 3'd7, 16'h1234, 8'h5A);
		queue_cmd(OP_LOAD, 3'd0, TURN_QUARTER, 8'hFF);
		queue_cmd(OP_LOAD, 3'd7, 16'hFFFF, 8'h01);
		queue_cmd(OP_TICK, 3'd0, 16'h0000, 8'h00);
		queue_cmd(OP_TICK, 3'd2, 16'hAAAA, 8'h55);
		settle();

		// Origin with no arms: a tick gives the center alone, flagged last.
		write_reg(REG_CENTER_X, 11'd0);
		write_reg(REG_CENTER_Y, 11'd0);
		write_reg(REG_PHASORS, 11'd0);
		queue_cmd(OP_TICK, 3'd1, 16'h5555, 8'hAA);
		settle();

		// Arm count beyond the table acts as the full table; an unused
		// register index must leave the settings alone.
		write_reg(REG_PHASORS, 11'd15);
		write_reg(REG_UNUSED, 11'h7FF);
		queue_cmd(OP_LOAD, 3'd3, 16'h8000, 8'hFF);
		queue_cmd(OP_LOAD, 3'd5, 16'h0100, 8'h80);
		queue_cmd(OP_TICK, 3'd6, 16'hFFFF, 8'hFF);
		queue_cmd(OP_TICK, 3'd4, 16'h0001, 8'h01);
		settle();

		// Random phases: fresh settings, then loads mixed among ticks.
		while (random_cmds < RANDOM_CMDS) begin
			write_reg(REG_CENTER_X, pick_center());
			write_reg(REG_CENTER_Y, pick_center());
			write_reg(REG_PHASORS, pick_arms());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, CENTER_W'($urandom));
			phase_len = $urandom_range(40, 80);
			for (int k = 0; k < phase_len; k++) begin
				r = $urandom_range(0, 9);
				case ($urandom_range(0, 5))
					0: rad = 8'hFF;
					1: rad = 8'h00;
					default: rad = RADIUS_W'($urandom);
				endcase
				case ($urandom_range(0, 4))
					0: stp = PHASE_W'($urandom_range(0, 255));
					1: stp = PHASE_W'(32'hFFFF - $urandom_range(0, 255));
					default: stp = PHASE_W'($urandom);
				endcase
				queue_cmd((r < 3) ? OP_LOAD : OP_TICK, 3'($urandom), stp, rad);
			end
			random_cmds += phase_len;
			settle();
		end

		// Nothing left to wait for here; check that no point stayed missing.
		settle();
		if (expected_points.size() != 0)
			report_fail($sformatf("%0d expected points never arrived",
				expected_points.size()));

		$display("covered %0d ticks and %0d loads over %0d register writes",
			ticks_done, loads_done, reg_writes);
		$display("checked %0d chain points, %0d of them clamped at the range end",
			points_checked, saturated_points);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d failures", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
